>>> design/dnte_pkg.sv
// shared constants, types and codes for the nested dmap tag extractor
package dnte_pkg;

    // position and length width of the message walk
    localparam int LEN_W     = 16;
    // nesting levels below the message itself
    localparam int MAX_DEPTH = 8;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    // text values are cut to TEXT_CAP-1 bytes
    localparam int TEXT_CAP  = 256;
    localparam int CNT_W     = $clog2(TEXT_CAP);
    // bytes in one item header: tag then length
    localparam int HDR_BYTES = 8;
    localparam int HCNT_W    = 4;

    // printable range used when probing for a nested container
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7e;

    // register reset values: "minm", "asar", "asal"
    localparam logic [31:0] TITLE_RESET  = 32'h6d696e6d;
    localparam logic [31:0] ARTIST_RESET = 32'h61736172;
    localparam logic [31:0] ALBUM_RESET  = 32'h6173616c;

    // configuration port address width
    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_TITLE  = 2'd0,
        REG_ARTIST = 2'd1,
        REG_ALBUM  = 2'd2
    } reg_index_t;

    // field codes on field_id
    localparam logic [1:0] FIELD_TITLE  = 2'd0;
    localparam logic [1:0] FIELD_ARTIST = 2'd1;
    localparam logic [1:0] FIELD_ALBUM  = 2'd2;
    localparam logic [1:0] FIELD_NONE   = 2'd3;

    // configured tag codes handed to the parser
    typedef struct packed {
        logic [31:0] title_tag;
        logic [31:0] artist_tag;
        logic [31:0] album_tag;
    } tag_cfg_t;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_HEADER  = 6'b000010,
        MODE_CAPTURE = 6'b000100,
        MODE_PROBE   = 6'b001000,
        MODE_SKIP    = 6'b010000,
        MODE_DONE    = 6'b100000
    } mode_t;

    // outcome of a complete header
    typedef struct packed {
        mode_t            mode;
        logic [LEN_W-1:0] vl;
        logic             hit_empty;
        logic             capture;
        logic [1:0]       field;
    } decide_t;

endpackage

>>> design/dnte_cfg_regs.sv
// configuration registers for the three tag codes, apb-style access
module dnte_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dnte_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output dnte_pkg::tag_cfg_t            tags
);
    import dnte_pkg::*;

    logic [31:0] title_reg;
    logic [31:0] artist_reg;
    logic [31:0] album_reg;
    logic [1:0]  widx;
    logic        wr_en;

    assign pready = 1'b1;
    assign widx   = paddr[ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            title_reg  <= TITLE_RESET;
            artist_reg <= ARTIST_RESET;
            album_reg  <= ALBUM_RESET;
        end
        else if (wr_en)
        begin
            if (widx == REG_TITLE)
                title_reg <= pwdata;
            if (widx == REG_ARTIST)
                artist_reg <= pwdata;
            if (widx == REG_ALBUM)
                album_reg <= pwdata;
        end
    end

    // read back
    always_comb
    begin
        unique case (widx)
            REG_TITLE:  prdata = title_reg;
            REG_ARTIST: prdata = artist_reg;
            REG_ALBUM:  prdata = album_reg;
            default:    prdata = 32'd0;
        endcase
    end

    assign tags.title_tag  = title_reg;
    assign tags.artist_tag = artist_reg;
    assign tags.album_tag  = album_reg;

endmodule

>>> design/dmap_nested_tag_extractor_core.sv
// top level of the nested dmap tag extractor: byte walk, container stack, text output
//
// The block takes one message byte per cycle while in_stall is low and returns at
// most one text request per byte. A byte is held in an input register, walked
// through the parser in a single pass, and its result is written to the output
// register when the parser advances; a new byte is accepted every cycle as long
// as the output register drains. The cycle is set by the header
// decision followed by the container pop, which compares every level of the
// nine-entry end-position stack in parallel. The stack needs no clearing after
// reset: levels are only read once written at message start or container entry.
// Title, artist and album tag codes are set through the apb-style registers at
// addresses 0, 4, 8.
module dmap_nested_tag_extractor_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dnte_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // byte input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          message_start,
    input  logic [15:0]                   message_length,
    // text output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    field_id,
    output logic [7:0]                    text_byte,
    output logic                          has_byte,
    output logic                          value_start,
    output logic                          value_end
);
    import dnte_pkg::*;

    localparam logic [CNT_W:0] TEXT_LIMIT = (CNT_W + 1)'(TEXT_CAP - 1);

    tag_cfg_t tags;

    dnte_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tags    (tags)
    );

    // input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_start_reg;
    logic [LEN_W-1:0] in_len_reg;

    // parser state
    mode_t              mode_reg,  mode_next;
    logic [LEN_W-1:0]   pos_reg,   pos_next;
    logic [63:0]        hwin_reg,  hwin_next;
    logic [HCNT_W-1:0]  hcnt_reg,  hcnt_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [LEN_W-1:0]   top_reg,   top_next;
    logic [LEN_W-1:0]   vl_reg,    vl_next;
    logic [1:0]         cfield_reg, cfield_next;
    logic [CNT_W-1:0]   ccnt_reg,  ccnt_next;
    logic [LEN_W-1:0]   end_reg  [MAX_DEPTH+1];
    logic [LEN_W-1:0]   end_next [MAX_DEPTH+1];

    // output register
    logic       out_valid_reg;
    logic [1:0] field_id_reg,  field_id_next;
    logic [7:0] text_byte_reg, text_byte_next;
    logic       has_byte_reg,  has_byte_next;
    logic       vstart_reg,    vstart_next;
    logic       vend_reg,      vend_next;
    logic       emit;

    logic advance;

    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign out_valid   = out_valid_reg;
    assign field_id    = field_id_reg;
    assign text_byte   = text_byte_reg;
    assign has_byte    = has_byte_reg;
    assign value_start = vstart_reg;
    assign value_end   = vend_reg;

    function automatic logic printable4(input logic [31:0] t);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (t[8*i +: 8] < PRINT_LO || t[8*i +: 8] > PRINT_HI)
                ok = 1'b0;
        end
        return ok;
    endfunction

    // decision on a complete header against the end of its container
    function automatic decide_t decide_header(input logic [63:0]      hwin,
                                              input logic [LEN_W-1:0] e,
                                              input logic [LEN_W-1:0] nxt,
                                              input tag_cfg_t         cfg);
        logic [31:0]      tag;
        logic [31:0]      n;
        logic [LEN_W-1:0] room;
        logic [1:0]       f;
        decide_t          d;
        tag  = hwin[63:32];
        n    = hwin[31:0];
        room = (e > nxt) ? (e - nxt) : '0;
        priority if (tag == cfg.title_tag)
            f = FIELD_TITLE;
        else if (tag == cfg.artist_tag)
            f = FIELD_ARTIST;
        else if (tag == cfg.album_tag)
            f = FIELD_ALBUM;
        else
            f = FIELD_NONE;
        d.mode      = MODE_HEADER;
        d.vl        = n[LEN_W-1:0];
        d.hit_empty = 1'b0;
        d.capture   = 1'b0;
        d.field     = f;
        if (n > {{(32-LEN_W){1'b0}}, room})
        begin
            // length overrun: drop what is left of the container
            d.vl   = room;
            d.mode = (room != '0) ? MODE_SKIP : MODE_HEADER;
        end
        else if (f != FIELD_NONE)
        begin
            if (n == 32'd0)
                d.hit_empty = 1'b1;
            else
            begin
                d.capture = 1'b1;
                d.mode    = MODE_CAPTURE;
            end
        end
        else if (n >= 32'(HDR_BYTES))
            d.mode = MODE_PROBE;
        else if (n != 32'd0)
            d.mode = MODE_SKIP;
        return d;
    endfunction

    // single-pass byte step
    always_comb
    begin
        mode_t              s_mode;
        logic [LEN_W-1:0]   s_pos;
        logic [LEN_W-1:0]   nxt;
        logic [LEN_W-1:0]   dec_e;
        logic [LEN_W-1:0]   push_end;
        logic [LEN_W-1:0]   gap;
        logic               do_decide;
        logic               last;
        logic               found;
        logic [DEPTH_W-1:0] k;
        decide_t            d;

        s_mode      = mode_reg;
        s_pos       = pos_reg;
        hwin_next   = hwin_reg;
        hcnt_next   = hcnt_reg;
        depth_next  = depth_reg;
        top_next    = top_reg;
        vl_next     = vl_reg;
        cfield_next = cfield_reg;
        ccnt_next   = ccnt_reg;
        for (int j = 0; j <= MAX_DEPTH; j++)
            end_next[j] = end_reg[j];

        emit           = 1'b0;
        field_id_next  = cfield_reg;
        text_byte_next = in_byte_reg;
        has_byte_next  = 1'b0;
        vstart_next    = 1'b0;
        vend_next      = 1'b0;

        nxt       = pos_reg + 1'b1;
        dec_e     = top_reg;
        push_end  = '0;
        gap       = '0;
        do_decide = 1'b0;
        last      = 1'b0;
        found     = 1'b0;
        k         = '0;
        d         = '0;

        // message start restarts the walk at level zero
        if (in_start_reg)
        begin
            s_pos       = '0;
            depth_next  = '0;
            end_next[0] = in_len_reg;
            top_next    = in_len_reg;
            hwin_next   = '0;
            hcnt_next   = '0;
            vl_next     = '0;
            ccnt_next   = '0;
            if (in_len_reg == '0)
                s_mode = MODE_DONE;
            else if (in_len_reg < LEN_W'(HDR_BYTES))
            begin
                s_mode  = MODE_SKIP;
                vl_next = in_len_reg;
            end
            else
                s_mode = MODE_HEADER;
        end

        mode_next = s_mode;
        pos_next  = s_pos;
        nxt       = s_pos + 1'b1;

        if (s_mode != MODE_IDLE && s_mode != MODE_DONE)
        begin
            unique case (s_mode)
                MODE_HEADER:
                begin
                    hwin_next = {hwin_next[55:0], in_byte_reg};
                    hcnt_next = hcnt_next + 1'b1;
                    if (hcnt_next == HCNT_W'(HDR_BYTES))
                    begin
                        do_decide = 1'b1;
                        dec_e     = top_next;
                    end
                end
                MODE_CAPTURE:
                begin
                    vl_next = vl_next - 1'b1;
                    if ({1'b0, ccnt_next} < TEXT_LIMIT)
                    begin
                        last = ({1'b0, ccnt_next} + 1'b1 == TEXT_LIMIT) || (vl_next == '0);
                        emit           = 1'b1;
                        field_id_next  = cfield_next;
                        text_byte_next = in_byte_reg;
                        has_byte_next  = 1'b1;
                        vstart_next    = (ccnt_next == '0);
                        vend_next      = last;
                        ccnt_next      = ccnt_next + 1'b1;
                    end
                    if (vl_next == '0)
                        mode_next = MODE_HEADER;
                end
                MODE_PROBE:
                begin
                    hwin_next = {hwin_next[55:0], in_byte_reg};
                    hcnt_next = hcnt_next + 1'b1;
                    vl_next   = vl_next - 1'b1;
                    if (hcnt_next == HCNT_W'(HDR_BYTES))
                    begin
                        hcnt_next = '0;
                        if (printable4(hwin_next[63:32]) &&
                            hwin_next[31:0] <= {{(32-LEN_W){1'b0}}, vl_next} &&
                            depth_next < DEPTH_W'(MAX_DEPTH))
                        begin
                            // enter the value as a nested container
                            push_end             = nxt + vl_next;
                            depth_next           = depth_next + 1'b1;
                            end_next[depth_next] = push_end;
                            top_next             = push_end;
                            do_decide            = 1'b1;
                            dec_e                = push_end;
                        end
                        else
                            mode_next = (vl_next != '0) ? MODE_SKIP : MODE_HEADER;
                    end
                end
                MODE_SKIP:
                begin
                    vl_next = vl_next - 1'b1;
                    if (vl_next == '0)
                        mode_next = MODE_HEADER;
                end
                default:
                begin
                    mode_next = s_mode;
                end
            endcase

            if (do_decide)
            begin
                d         = decide_header(hwin_next, dec_e, nxt, tags);
                hcnt_next = '0;
                mode_next = d.mode;
                vl_next   = d.vl;
                if (d.hit_empty)
                begin
                    emit           = 1'b1;
                    field_id_next  = d.field;
                    text_byte_next = 8'd0;
                    has_byte_next  = 1'b0;
                    vstart_next    = 1'b1;
                    vend_next      = 1'b1;
                end
                if (d.capture)
                begin
                    cfield_next = d.field;
                    ccnt_next   = '0;
                end
            end

            pos_next = nxt;

            // item boundary: pop finished containers, skip short tails
            if (mode_next == MODE_HEADER && hcnt_next == '0)
            begin
                for (int j = 0; j <= MAX_DEPTH; j++)
                begin
                    if (DEPTH_W'(j) <= depth_next && nxt < end_next[j])
                    begin
                        found = 1'b1;
                        k     = DEPTH_W'(j);
                    end
                end
                if (!found)
                begin
                    mode_next  = MODE_DONE;
                    depth_next = '0;
                end
                else
                begin
                    depth_next = k;
                    top_next   = end_next[k];
                    gap        = end_next[k] - nxt;
                    if (gap < LEN_W'(HDR_BYTES))
                    begin
                        vl_next   = gap;
                        mode_next = MODE_SKIP;
                    end
                end
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg  <= data_byte;
            in_start_reg <= message_start;
            in_len_reg   <= message_length;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            hwin_reg   <= '0;
            hcnt_reg   <= '0;
            depth_reg  <= '0;
            top_reg    <= '0;
            vl_reg     <= '0;
            cfield_reg <= '0;
            ccnt_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            hwin_reg   <= hwin_next;
            hcnt_reg   <= hcnt_next;
            depth_reg  <= depth_next;
            top_reg    <= top_next;
            vl_reg     <= vl_next;
            cfield_reg <= cfield_next;
            ccnt_reg   <= ccnt_next;
        end
    end

    // container end stack
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int j = 0; j <= MAX_DEPTH; j++)
                end_reg[j] <= end_next[j];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!(out_valid_reg && out_stall))
            out_valid_reg <= advance && emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            field_id_reg  <= field_id_next;
            text_byte_reg <= text_byte_next;
            has_byte_reg  <= has_byte_next;
            vstart_reg    <= vstart_next;
            vend_reg      <= vend_next;
        end
    end

endmodule
